[sv/ffpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants, codes and table entry types of the pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int FREE_ENTRIES   = 32;
   localparam int FREE_IDX_W     = $clog2(FREE_ENTRIES);
   localparam int FREE_CNT_W     = $clog2(FREE_ENTRIES + 1);
   localparam int SLOT_ENTRIES   = 32;
   localparam int SLOT_IDX_W     = $clog2(SLOT_ENTRIES);
   localparam int SLOT_CNT_W     = $clog2(SLOT_ENTRIES + 1);
   localparam int POOL_BITS      = 18;
   localparam int POS_W          = POOL_BITS;
   localparam int LEN_W          = POOL_BITS + 1;
   localparam int ARITH_W        = LEN_W + 1;
   localparam int SIZE_W         = 16;
   localparam int ALIGN_W        = 3;
   localparam int REF_W          = 16;
   localparam int HEADER_BYTES   = 8;
   localparam int MAX_ALIGN_LOG2 = 6;
   localparam int POOL_RESET     = 256 * 1024;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [REF_W-1:0] REFS_MAX = '1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RETAIN  = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_UNKNOWN    = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_REF_ERROR  = 3'd4
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] REG_POOL_BYTES = 3'd0;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [LEN_W-1:0] length;
   } free_entry_type;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic [REF_W-1:0] refs;
   } slot_entry_type;

endpackage
`default_nettype wire

[sv/ffpa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/ffpa_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_csr
// register port holding the pool size; a write requests table reinitialisation
// ----------------------------------------------------------------------------
module ffpa_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ffpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ffpa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ffpa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic [ffpa_pkg::LEN_W-1:0]           pool_bytes,
   output logic                                 init_req
);
   import ffpa_pkg::*;

   logic [LEN_W-1:0]   pool_ff, pool_in;
   logic               init_ff, init_in;
   logic [ARITH_W-1:0] rounded;
   logic               wr_hit;

   assign wr_hit  = csr_psel & csr_penable & csr_pwrite & (csr_paddr == REG_POOL_BYTES);
   assign rounded = ({1'b0, csr_pwdata[LEN_W-1:0]} + ARITH_W'(3)) & ~ARITH_W'(3);

   always_comb begin
      pool_in = pool_ff;
      init_in = 1'b0;
      if (wr_hit) begin
         init_in = 1'b1;
         // limit to the addressable pool
         if (rounded > ARITH_W'(1 << POOL_BITS)) begin
            pool_in = LEN_W'(1 << POOL_BITS);
         end else begin
            pool_in = rounded[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= LEN_W'(POOL_RESET);
         init_ff <= 1'b0;
      end else begin
         pool_ff <= pool_in;
         init_ff <= init_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_POOL_BYTES) ? CSR_DATA_W'(pool_ff) : '0;
   assign csr_pready = 1'b1;
   assign pool_bytes = pool_ff;
   assign init_req   = init_ff;

endmodule
`default_nettype wire

[sv/first_fit_pool_allocator_refcount_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_refcount_unit
// first-fit pool allocator with coalescing free list and slot reference counts
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one response. The free-run list
// and the slot table each live in a ram with registered read data, walked by
// a single sequencer. An allocate reads and checks each free run in turn, and
// when an emptied run is removed the runs behind it move up one place. Free,
// retain and release scan the slot table, reading each valid slot, to find the
// position; a free, or a release that frees the slot, then walks the runs to
// find its neighbours and moves runs on a merge or an insert. The response
// sits in an output register so the next request can be taken while it waits.
// After reset the tables are reinitialised in S_INIT; a pool_bytes write
// reaches the sequencer through a register and then reinitialises in S_INIT.
// No request is taken during either.
module first_fit_pool_allocator_refcount_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // alloc_size[15:0], align_log2[18:16], position[36:19], zero fill
   input  wire logic [39:0]                     req_tdata,
   // operation[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // slot_position[17:0], data_offset[35:18], ref_count[51:36], freed[52], zero fill
   output logic [55:0]                          rsp_tdata,
   // status[2:0]
   output logic [2:0]                           rsp_tuser,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ffpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ffpa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ffpa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import ffpa_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_A_RD, S_A_EV1, S_A_EV2, S_F_RD, S_F_CMP, S_F_ACT,
      S_G_RD, S_G_CHK, S_G_ACT, S_SH_RD, S_SH_WR, S_DONE
   } state_type;

   logic [LEN_W-1:0] pool_bytes;
   logic             init_req;

   ffpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pool_bytes  (pool_bytes),
      .init_req    (init_req)
   );

   // ram ports
   logic                  fwr_en, frd_en, swr_en, srd_en;
   logic [FREE_IDX_W-1:0] fwr_addr, frd_addr;
   logic [SLOT_IDX_W-1:0] swr_addr, srd_addr;
   free_entry_type        fwr_data, frd_data;
   slot_entry_type        swr_data, srd_data;

   ffpa_ram #(.WIDTH($bits(free_entry_type)), .DEPTH(FREE_ENTRIES)) u_free_ram (
      .clock   (clock),
      .wr_en   (fwr_en),
      .wr_addr (fwr_addr),
      .wr_data (fwr_data),
      .rd_en   (frd_en),
      .rd_addr (frd_addr),
      .rd_data (frd_data)
   );

   ffpa_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(SLOT_ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (swr_en),
      .wr_addr (swr_addr),
      .wr_data (swr_data),
      .rd_en   (srd_en),
      .rd_addr (srd_addr),
      .rd_data (srd_data)
   );

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ALIGN_W-1:0]    align_ff, align_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [FREE_CNT_W-1:0] idx_ff, idx_in;
   logic [FREE_CNT_W-1:0] count_ff, count_in;
   logic [SLOT_CNT_W-1:0] scan_ff, scan_in;
   logic [SLOT_IDX_W-1:0] sel_ff, sel_in;
   logic [SLOT_ENTRIES-1:0] valid_ff, valid_in;
   logic [POS_W-1:0]      st_ff, st_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ARITH_W-1:0]    al_ff, al_in;
   logic                  fit_ff, fit_in;
   logic [LEN_W-1:0]      slen_ff, slen_in;
   logic [REF_W-1:0]      refs_ff, refs_in;
   logic                  before_ff, before_in;
   logic                  look_after_ff, look_after_in;
   logic                  after_ff, after_in;
   logic [FREE_IDX_W-1:0] bidx_ff, bidx_in;
   logic [POS_W-1:0]      bstart_ff, bstart_in;
   logic [LEN_W-1:0]      blen_ff, blen_in;
   logic [LEN_W-1:0]      alen_ff, alen_in;
   logic                  insert_ff, insert_in;
   logic [FREE_IDX_W-1:0] ins_idx_ff, ins_idx_in;
   free_entry_type        pend_ff, pend_in;
   status_type            res_status_ff, res_status_in;
   logic [POS_W-1:0]      res_spos_ff, res_spos_in;
   logic [POS_W-1:0]      res_doff_ff, res_doff_in;
   logic [REF_W-1:0]      res_refs_ff, res_refs_in;
   logic                  res_freed_ff, res_freed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]      rsp_spos_ff, rsp_spos_in;
   logic [POS_W-1:0]      rsp_doff_ff, rsp_doff_in;
   logic [REF_W-1:0]      rsp_refs_ff, rsp_refs_in;
   logic                  rsp_freed_ff, rsp_freed_in;

   // request fields
   logic [SIZE_W-1:0]  req_size;
   logic [ALIGN_W-1:0] req_align;
   logic [POS_W-1:0]   req_pos;

   assign req_size  = req_tdata[15:0];
   assign req_align = req_tdata[18:16];
   assign req_pos   = req_tdata[36:19];

   // allocate arithmetic
   logic [ARITH_W-1:0] mask, data_at, al_raw, slot_end, gap;
   logic [LEN_W-1:0]   cut_len;
   logic [ARITH_W-1:0] end_pos;
   logic               free_found;
   logic [SLOT_IDX_W-1:0] free_slot;

   assign mask    = (ARITH_W'(1) << align_ff) - ARITH_W'(1);
   assign data_at = ARITH_W'(frd_data.start) + ARITH_W'(HEADER_BYTES);
   assign al_raw  = (data_at + mask) & ~mask;
   assign gap     = al_ff - (ARITH_W'(st_ff) + ARITH_W'(HEADER_BYTES)) + ARITH_W'(size_ff);
   assign slot_end = (al_ff + ARITH_W'(size_ff) + ARITH_W'(3)) & ~ARITH_W'(3);
   assign cut_len = LEN_W'(slot_end - ARITH_W'(st_ff));
   assign end_pos = ARITH_W'(pos_ff) + ARITH_W'(slen_ff);

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = SLOT_ENTRIES - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_found = 1'b1;
            free_slot  = SLOT_IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      sel_in        = sel_ff;
      valid_in      = valid_ff;
      st_in         = st_ff;
      len_in        = len_ff;
      al_in         = al_ff;
      fit_in        = fit_ff;
      slen_in       = slen_ff;
      refs_in       = refs_ff;
      before_in     = before_ff;
      look_after_in = look_after_ff;
      after_in      = after_ff;
      bidx_in       = bidx_ff;
      bstart_in     = bstart_ff;
      blen_in       = blen_ff;
      alen_in       = alen_ff;
      insert_in     = insert_ff;
      ins_idx_in    = ins_idx_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_spos_in   = res_spos_ff;
      res_doff_in   = res_doff_ff;
      res_refs_in   = res_refs_ff;
      res_freed_in  = res_freed_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_spos_in   = rsp_spos_ff;
      rsp_doff_in   = rsp_doff_ff;
      rsp_refs_in   = rsp_refs_ff;
      rsp_freed_in  = rsp_freed_ff;
      fwr_en   = 1'b0;
      fwr_addr = idx_ff[FREE_IDX_W-1:0];
      fwr_data = '0;
      frd_en   = 1'b0;
      frd_addr = idx_ff[FREE_IDX_W-1:0];
      swr_en   = 1'b0;
      swr_addr = sel_ff;
      swr_data = '0;
      srd_en   = 1'b0;
      srd_addr = scan_ff[SLOT_IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            fwr_en          = 1'b1;
            fwr_addr        = '0;
            fwr_data.start  = '0;
            fwr_data.length = pool_bytes;
            count_in        = (pool_bytes != '0) ? FREE_CNT_W'(1) : '0;
            valid_in        = '0;
            state_in        = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && !init_req) begin
               op_in    = op_type'(req_tuser);
               size_in  = req_size;
               align_in = (req_align > ALIGN_W'(MAX_ALIGN_LOG2)) ?
                          ALIGN_W'(MAX_ALIGN_LOG2) : req_align;
               pos_in   = req_pos;
               res_spos_in  = '0;
               res_doff_in  = '0;
               res_refs_in  = '0;
               res_freed_in = 1'b0;
               if (op_type'(req_tuser) == OP_ALLOC) begin
                  if (!free_found) begin
                     res_status_in = ST_TABLE_FULL;
                     state_in      = S_DONE;
                  end else begin
                     sel_in   = free_slot;
                     idx_in   = '0;
                     state_in = S_A_RD;
                  end
               end else begin
                  res_spos_in = req_pos;
                  scan_in     = '0;
                  state_in    = S_F_RD;
               end
            end
         end
         S_A_RD: begin
            if (idx_ff < count_ff) begin
               frd_en   = 1'b1;
               state_in = S_A_EV1;
            end else begin
               res_status_in = ST_NO_SPACE;
               state_in      = S_DONE;
            end
         end
         S_A_EV1: begin
            st_in    = frd_data.start;
            len_in   = frd_data.length;
            fit_in   = ARITH_W'(frd_data.length) >= ARITH_W'(size_ff) + ARITH_W'(HEADER_BYTES);
            al_in    = al_raw;
            state_in = S_A_EV2;
         end
         S_A_EV2: begin
            if (fit_ff && (gap <= ARITH_W'(len_ff) - ARITH_W'(HEADER_BYTES))) begin
               fwr_en          = 1'b1;
               fwr_data.start  = POS_W'(ARITH_W'(st_ff) + ARITH_W'(cut_len));
               fwr_data.length = len_ff - cut_len;
               swr_en          = 1'b1;
               swr_data.start  = st_ff;
               swr_data.length = cut_len;
               swr_data.refs   = '0;
               valid_in[sel_ff] = 1'b1;
               res_status_in   = ST_OK;
               res_spos_in     = st_ff;
               res_doff_in     = POS_W'(al_ff);
               if (len_ff == cut_len) begin
                  // emptied run leaves the list
                  insert_in = 1'b0;
                  state_in  = S_SH_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               idx_in   = idx_ff + FREE_CNT_W'(1);
               state_in = S_A_RD;
            end
         end
         S_F_RD: begin
            if (scan_ff == SLOT_CNT_W'(SLOT_ENTRIES)) begin
               res_status_in = ST_UNKNOWN;
               state_in      = S_DONE;
            end else if (valid_ff[scan_ff[SLOT_IDX_W-1:0]]) begin
               srd_en   = 1'b1;
               state_in = S_F_CMP;
            end else begin
               scan_in = scan_ff + SLOT_CNT_W'(1);
            end
         end
         S_F_CMP: begin
            if (srd_data.start == pos_ff) begin
               sel_in   = scan_ff[SLOT_IDX_W-1:0];
               slen_in  = srd_data.length;
               refs_in  = srd_data.refs;
               state_in = S_F_ACT;
            end else begin
               scan_in  = scan_ff + SLOT_CNT_W'(1);
               state_in = S_F_RD;
            end
         end
         S_F_ACT: begin
            swr_data.start  = pos_ff;
            swr_data.length = slen_ff;
            idx_in          = '0;
            before_in       = 1'b0;
            look_after_in   = 1'b0;
            res_refs_in     = refs_ff;
            state_in        = S_DONE;
            case (op_ff)
               OP_FREE: begin
                  if (refs_ff != '0) begin
                     res_status_in = ST_REF_ERROR;
                  end else begin
                     state_in = S_G_RD;
                  end
               end
               OP_RETAIN: begin
                  if (refs_ff == REFS_MAX) begin
                     res_status_in = ST_REF_ERROR;
                  end else begin
                     swr_en        = 1'b1;
                     swr_data.refs = refs_ff + REF_W'(1);
                     res_refs_in   = refs_ff + REF_W'(1);
                     res_status_in = ST_OK;
                  end
               end
               default: begin
                  if (refs_ff == '0) begin
                     res_status_in = ST_REF_ERROR;
                  end else if (refs_ff == REF_W'(1)) begin
                     state_in = S_G_RD;
                  end else begin
                     swr_en        = 1'b1;
                     swr_data.refs = refs_ff - REF_W'(1);
                     res_refs_in   = refs_ff - REF_W'(1);
                     res_status_in = ST_OK;
                  end
               end
            endcase
         end
         S_G_RD: begin
            if (idx_ff < count_ff) begin
               frd_en   = 1'b1;
               state_in = S_G_CHK;
            end else begin
               after_in = 1'b0;
               state_in = S_G_ACT;
            end
         end
         S_G_CHK: begin
            if (look_after_ff || (frd_data.start > pos_ff)) begin
               after_in = ARITH_W'(frd_data.start) == end_pos;
               alen_in  = frd_data.length;
               state_in = S_G_ACT;
            end else if (ARITH_W'(frd_data.start) + ARITH_W'(frd_data.length) ==
                         ARITH_W'(pos_ff)) begin
               before_in     = 1'b1;
               bidx_in       = idx_ff[FREE_IDX_W-1:0];
               bstart_in     = frd_data.start;
               blen_in       = frd_data.length;
               look_after_in = 1'b1;
               idx_in        = idx_ff + FREE_CNT_W'(1);
               state_in      = S_G_RD;
            end else begin
               idx_in   = idx_ff + FREE_CNT_W'(1);
               state_in = S_G_RD;
            end
         end
         S_G_ACT: begin
            res_status_in = ST_OK;
            res_refs_in   = '0;
            res_freed_in  = 1'b1;
            valid_in[sel_ff] = 1'b0;
            state_in      = S_DONE;
            if (before_ff) begin
               fwr_en         = 1'b1;
               fwr_addr       = bidx_ff;
               fwr_data.start = bstart_ff;
               if (after_ff) begin
                  // both neighbours merge, the following run goes away
                  fwr_data.length = blen_ff + slen_ff + alen_ff;
                  insert_in       = 1'b0;
                  state_in        = S_SH_RD;
               end else begin
                  fwr_data.length = blen_ff + slen_ff;
               end
            end else if (after_ff) begin
               fwr_en          = 1'b1;
               fwr_data.start  = pos_ff;
               fwr_data.length = alen_ff + slen_ff;
            end else if (count_ff >= FREE_CNT_W'(FREE_ENTRIES)) begin
               res_status_in    = ST_TABLE_FULL;
               res_refs_in      = refs_ff;
               res_freed_in     = 1'b0;
               valid_in[sel_ff] = 1'b1;
            end else begin
               pend_in.start  = pos_ff;
               pend_in.length = slen_ff;
               ins_idx_in     = idx_ff[FREE_IDX_W-1:0];
               idx_in         = count_ff;
               insert_in      = 1'b1;
               state_in       = S_SH_RD;
            end
         end
         S_SH_RD: begin
            if (insert_ff) begin
               if (idx_ff > FREE_CNT_W'(ins_idx_ff)) begin
                  frd_en   = 1'b1;
                  frd_addr = FREE_IDX_W'(idx_ff - FREE_CNT_W'(1));
                  state_in = S_SH_WR;
               end else begin
                  fwr_en   = 1'b1;
                  fwr_addr = ins_idx_ff;
                  fwr_data = pend_ff;
                  count_in = count_ff + FREE_CNT_W'(1);
                  state_in = S_DONE;
               end
            end else begin
               if (idx_ff + FREE_CNT_W'(1) < count_ff) begin
                  frd_en   = 1'b1;
                  frd_addr = FREE_IDX_W'(idx_ff + FREE_CNT_W'(1));
                  state_in = S_SH_WR;
               end else begin
                  count_in = count_ff - FREE_CNT_W'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_SH_WR: begin
            fwr_en   = 1'b1;
            fwr_data = frd_data;
            idx_in   = insert_ff ? idx_ff - FREE_CNT_W'(1) : idx_ff + FREE_CNT_W'(1);
            state_in = S_SH_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_spos_in   = res_spos_ff;
               rsp_doff_in   = res_doff_ff;
               rsp_refs_in   = res_refs_ff;
               rsp_freed_in  = res_freed_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (init_req) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      align_ff      <= align_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      sel_ff        <= sel_in;
      st_ff         <= st_in;
      len_ff        <= len_in;
      al_ff         <= al_in;
      fit_ff        <= fit_in;
      slen_ff       <= slen_in;
      refs_ff       <= refs_in;
      before_ff     <= before_in;
      look_after_ff <= look_after_in;
      after_ff      <= after_in;
      bidx_ff       <= bidx_in;
      bstart_ff     <= bstart_in;
      blen_ff       <= blen_in;
      alen_ff       <= alen_in;
      insert_ff     <= insert_in;
      ins_idx_ff    <= ins_idx_in;
      pend_ff       <= pend_in;
      res_status_ff <= res_status_in;
      res_spos_ff   <= res_spos_in;
      res_doff_ff   <= res_doff_in;
      res_refs_ff   <= res_refs_in;
      res_freed_ff  <= res_freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_spos_ff   <= rsp_spos_in;
      rsp_doff_ff   <= rsp_doff_in;
      rsp_refs_ff   <= rsp_refs_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   // no request while a pool_bytes write is pending
   assign req_tready = (state_ff == S_IDLE) && !init_req;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_freed_ff, rsp_refs_ff, rsp_doff_ff, rsp_spos_ff};

endmodule
`default_nettype wire

[test/tb_first_fit_pool_allocator_refcount_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator_refcount_unit
// self-checking bench for the first-fit pool allocator with reference counts
// ----------------------------------------------------------------------------
// Requests are driven on the req stream while a behavioural allocator in the
// bench keeps its own free-run list and slot table, predicts each response and
// queues it. A monitor compares each accepted response field by field. Pool
// size is changed between phases through the csr port while the block idles.
module tb_first_fit_pool_allocator_refcount_unit;
   import ffpa_pkg::*;

   localparam int IDLE_GAP = 400;
   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   always #5 clock = ~clock;

   first_fit_pool_allocator_refcount_unit uut (.*);

   typedef struct packed {
      status_type status;
      logic [POS_W-1:0] slot_pos;
      logic [POS_W-1:0] data_off;
      logic [REF_W-1:0] refs;
      logic freed;
   } outcome_type;

   // allocator shadow
   logic [LEN_W-1:0] pool_size;
   logic [POS_W-1:0] run_start [FREE_ENTRIES];
   logic [LEN_W-1:0] run_len [FREE_ENTRIES];
   int run_count;
   bit live [SLOT_ENTRIES];
   logic [POS_W-1:0] live_start [SLOT_ENTRIES];
   logic [LEN_W-1:0] live_len [SLOT_ENTRIES];
   logic [REF_W-1:0] live_refs [SLOT_ENTRIES];

   outcome_type pending_outcomes[$];
   int errors = 0;
   int n_sent = 0, n_rcvd = 0, n_freed = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int quiet_cycles = 0;

   task automatic shadow_pool(input logic [18:0] v);
      logic [19:0] r;
      r = ({1'b0, v} + 20'd3) & ~20'd3;
      if (r > (20'd1 << POOL_BITS)) r = 20'd1 << POOL_BITS;
      pool_size = r[LEN_W-1:0];
      for (int k = 0; k < FREE_ENTRIES; k++) begin
         run_start[k] = '0;
         run_len[k] = '0;
      end
      for (int k = 0; k < SLOT_ENTRIES; k++) live[k] = 0;
      run_len[0] = pool_size;
      run_count = (pool_size != 0) ? 1 : 0;
   endtask

   function automatic void drop_run(input int i);
      for (int k = i; k + 1 < run_count; k++) begin
         run_start[k] = run_start[k+1];
         run_len[k] = run_len[k+1];
      end
      run_count--;
   endfunction

   // returns the slot's bytes to the list, merging with neighbours
   function automatic status_type return_slot(input int s);
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] len;
      int i, prev;
      bit next;
      pos = live_start[s];
      len = live_len[s];
      prev = -1;
      for (i = 0; i < run_count; i++) begin
         if (run_start[i] > pos) break;
         if (longint'(run_start[i]) + run_len[i] == pos) begin
            prev = i;
            i++;
            break;
         end
      end
      next = (i < run_count) && (longint'(run_start[i]) == longint'(pos) + len);
      if (prev >= 0) begin
         run_len[prev] = run_len[prev] + len;
         if (next) begin
            run_len[prev] = run_len[prev] + run_len[i];
            drop_run(i);
         end
      end else if (next) begin
         run_start[i] = pos;
         run_len[i] = run_len[i] + len;
      end else begin
         if (run_count >= FREE_ENTRIES) return ST_TABLE_FULL;
         for (int k = run_count; k > i; k--) begin
            run_start[k] = run_start[k-1];
            run_len[k] = run_len[k-1];
         end
         run_start[i] = pos;
         run_len[i] = len;
         run_count++;
      end
      live[s] = 0;
      return ST_OK;
   endfunction

   function automatic outcome_type predict_outcome(input op_type op, input logic [15:0] size,
                                                   input logic [2:0] align,
                                                   input logic [POS_W-1:0] pos);
      outcome_type o;
      int s;
      longint m, st, len, dstart, al, fin, slen;
      o = '0;
      o.status = ST_OK;
      s = -1;
      if (op == OP_ALLOC) begin
         if (align > MAX_ALIGN_LOG2) align = 3'(MAX_ALIGN_LOG2);
         for (int k = 0; k < SLOT_ENTRIES; k++)
            if (!live[k]) begin
               s = k;
               break;
            end
         if (s < 0) begin
            o.status = ST_TABLE_FULL;
         end else begin
            m = (longint'(1) << align) - 1;
            o.status = ST_NO_SPACE;
            for (int i = 0; i < run_count; i++) begin
               st = run_start[i];
               len = run_len[i];
               if (len < size + HEADER_BYTES) continue;
               dstart = st + HEADER_BYTES;
               al = (dstart + m) & ~m;
               if ((al - dstart) + size > len - HEADER_BYTES) continue;
               fin = (al + size + 3) & ~longint'(3);
               slen = fin - st;
               run_start[i] = POS_W'(st + slen);
               run_len[i] = LEN_W'(len - slen);
               if (run_len[i] == 0) drop_run(i);
               live[s] = 1;
               live_start[s] = POS_W'(st);
               live_len[s] = LEN_W'(slen);
               live_refs[s] = '0;
               o.status = ST_OK;
               o.slot_pos = POS_W'(st);
               o.data_off = POS_W'(al);
               break;
            end
         end
      end else begin
         for (int k = 0; k < SLOT_ENTRIES; k++)
            if (live[k] && live_start[k] == pos) begin
               s = k;
               break;
            end
         o.slot_pos = pos;
         if (s < 0) begin
            o.status = ST_UNKNOWN;
         end else if (op == OP_FREE) begin
            if (live_refs[s] != 0) begin
               o.status = ST_REF_ERROR;
               o.refs = live_refs[s];
            end else begin
               o.status = return_slot(s);
               o.freed = (o.status == ST_OK);
            end
         end else if (op == OP_RETAIN) begin
            if (live_refs[s] == REFS_MAX) o.status = ST_REF_ERROR;
            else live_refs[s]++;
            o.refs = live_refs[s];
         end else begin
            if (live_refs[s] == 0) begin
               o.status = ST_REF_ERROR;
            end else if (live_refs[s] == 1) begin
               o.status = return_slot(s);
               if (o.status == ST_OK) begin
                  live_refs[s] = 0;
                  o.freed = 1;
               end
               o.refs = live_refs[s];
            end else begin
               live_refs[s]--;
               o.refs = live_refs[s];
            end
         end
      end
      return o;
   endfunction

   task automatic send_request(input op_type op, input logic [15:0] size,
                               input logic [2:0] align, input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b0, pos, align, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(predict_outcome(op, size, align, pos));
      n_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_pool(input logic [18:0] v);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_POOL_BYTES;
      csr_pwdata <= {13'b0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      shadow_pool(v);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // pick a live slot position most of the time, otherwise any position
   function automatic logic [POS_W-1:0] pick_position();
      int idx[$];
      for (int k = 0; k < SLOT_ENTRIES; k++) if (live[k]) idx.push_back(k);
      if (idx.size() != 0 && $urandom_range(9) < 8)
         return live_start[idx[$urandom_range(idx.size() - 1)]];
      return POS_W'($urandom());
   endfunction

   // response monitor
   always @(posedge clock) begin
      outcome_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tuser);
         got.slot_pos = rsp_tdata[17:0];
         got.data_off = rsp_tdata[35:18];
         got.refs = rsp_tdata[51:36];
         got.freed = rsp_tdata[52];
         n_rcvd++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (want.status === ST_OK && want.freed) n_freed++;
            if (got.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.slot_pos !== want.slot_pos)
               $display("%0t: slot_position exp %0d got %0d", $time, want.slot_pos,
                        got.slot_pos);
            if (got.data_off !== want.data_off)
               $display("%0t: data_offset exp %0d got %0d", $time, want.data_off,
                        got.data_off);
            if (got.refs !== want.refs)
               $display("%0t: ref_count exp %0d got %0d", $time, want.refs, got.refs);
            if (got.freed !== want.freed)
               $display("%0t: freed exp %0d got %0d", $time, want.freed, got.freed);
            if (got !== want) errors++;
         end
      end
   end

   // receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("tb_first_fit_pool_allocator_refcount_unit: errors");
         $finish;
      end
   end

   task automatic test_directed_alloc();
      send_request(OP_ALLOC, 16'd0, 3'd0, '0);
      send_request(OP_ALLOC, 16'd1, 3'd7, '0);
      send_request(OP_ALLOC, 16'd13, 3'd6, '0);
      send_request(OP_ALLOC, 16'hFFFF, 3'd2, '0);
      send_request(OP_ALLOC, 16'd5, 3'd3, '0);
      send_request(OP_FREE, 16'd0, 3'd0, 18'h3FFFF);
   endtask

   task automatic test_directed_refs();
      logic [POS_W-1:0] p;
      p = live_start[0];
      send_request(OP_RELEASE, 16'd0, 3'd0, p);
      send_request(OP_RETAIN, 16'd0, 3'd0, p);
      send_request(OP_RETAIN, 16'd0, 3'd0, p);
      send_request(OP_FREE, 16'd0, 3'd0, p);
      send_request(OP_RELEASE, 16'd0, 3'd0, p);
      send_request(OP_RELEASE, 16'd0, 3'd0, p);
      send_request(OP_RETAIN, 16'd0, 3'd0, p);
      send_request(OP_FREE, 16'd0, 3'd0, live_start[2]);
      send_request(OP_FREE, 16'd0, 3'd0, live_start[1]);
   endtask

   // pin one slot near the count ceiling via retains is too slow; use small pools
   task automatic test_table_limits();
      write_pool(19'd1024);
      for (int k = 0; k < 33; k++) send_request(OP_ALLOC, 16'd0, 3'd0, '0);
      // free every other slot to fragment the list, then the rest
      for (int k = 0; k < 32; k += 2) send_request(OP_FREE, 16'd0, 3'd0, 18'(k * 8));
      for (int k = 1; k < 32; k += 2) send_request(OP_FREE, 16'd0, 3'd0, 18'(k * 8));
      write_pool(19'd0);
      send_request(OP_ALLOC, 16'd0, 3'd0, '0);
      write_pool(19'd13);
      send_request(OP_ALLOC, 16'd6, 3'd0, '0);
      send_request(OP_ALLOC, 16'd0, 3'd0, '0);
      write_pool(19'h7FFFF);
   endtask

   task automatic test_random(input int count);
      logic [15:0] sz;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            sz = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'($urandom_range(200));
            send_request(OP_ALLOC, sz, 3'($urandom()), POS_W'($urandom()));
         end else if (r < 65) begin
            send_request(OP_FREE, 16'($urandom()), 3'($urandom()), pick_position());
         end else if (r < 82) begin
            send_request(OP_RETAIN, 16'($urandom()), 3'($urandom()), pick_position());
         end else begin
            send_request(OP_RELEASE, 16'($urandom()), 3'($urandom()), pick_position());
         end
      end
   endtask

   initial begin
      shadow_pool(19'(POOL_RESET));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 38;
      recv_idle_pct = 78;
      test_directed_alloc();
      test_directed_refs();
      test_table_limits();
      test_random(500);
      send_idle_pct = 78;
      recv_idle_pct = 38;
      write_pool(19'd2000);
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_pool(19'd16);
      test_random(100);
      write_pool(19'd600);
      test_random(600);
      wait_drained();
      $display("ran %0d requests, %0d responses checked, %0d returned to the free list",
               n_sent, n_rcvd, n_freed);
      $display("pool sizes 0, 13, 16, 600, 1024, 2000 and full, with table overflow");
      if (errors == 0) begin
         $display("tb_first_fit_pool_allocator_refcount_unit: clean");
      end else begin
         $display("tb_first_fit_pool_allocator_refcount_unit: errors");
      end
      $finish;
   end
endmodule

[sim.f]
sv/ffpa_pkg.sv
sv/ffpa_ram.sv
sv/ffpa_csr.sv
sv/first_fit_pool_allocator_refcount_unit.sv
test/tb_first_fit_pool_allocator_refcount_unit.sv
